/* hw/rtl/agvg_pkg.sv */
// shared constants, codes and helper functions of the arrow glyph vertex generator
// used by hw/rtl/arrow_glyph_vertex_generator.sv, no dependencies
package agvg_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_AXIS_U_X     = 3'd0,
    REG_AXIS_U_Y     = 3'd1,
    REG_AXIS_U_Z     = 3'd2,
    REG_AXIS_V_X     = 3'd3,
    REG_AXIS_V_Y     = 3'd4,
    REG_AXIS_V_Z     = 3'd5,
    REG_ARROW_LENGTH = 3'd6
  } reg_idx_e;

  // vertex order of one arrow
  typedef enum logic [2:0] {
    VTX_BASE   = 3'd0,
    VTX_TIP0   = 3'd1,
    VTX_BARB_A = 3'd2,
    VTX_TIP1   = 3'd3,
    VTX_BARB_B = 3'd4,
    VTX_TIP2   = 3'd5
  } vtx_e;

  // target magnitude ranges of the direction normalizer
  localparam logic [4:0] RS_K_DIR  = 5'd30;
  localparam logic [4:0] RS_K_AXIS = 5'd24;

  // 0.8 and 0.1 in q0.30
  localparam logic [29:0] K_08 = 30'd858993459;
  localparam logic [29:0] K_01 = 30'd107374182;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic logic [63:0] max3(input logic [63:0] a, input logic [63:0] b,
                                       input logic [63:0] c);
    logic [63:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // shift a magnitude by the power of two that brings mx into [2^(k-1), 2^k)
  function automatic logic [30:0] rescale_mag(input logic [63:0] mag, input logic [63:0] mx,
                                              input logic [4:0] k);
    logic [6:0]  e;
    logic [6:0]  kk;
    logic [63:0] r;
    e  = '0;
    kk = {2'b00, k};
    for (int i = 0; i < 64; i++) begin
      if (mx[i]) e = 7'(i);
    end
    if (mx == '0) begin
      r = '0;
    end else if (e >= kk) begin
      r = mag >> (e - kk + 7'd1);
    end else begin
      r = mag << (kk - 7'd1 - e);
    end
    return r[30:0];
  endfunction

  function automatic logic signed [30:0] to_s31(input logic [30:0] m, input logic neg);
    return neg ? $signed(~m + 31'd1) : $signed(m);
  endfunction

endpackage

/* hw/rtl/arrow_glyph_vertex_generator.sv */
// arrow glyph vertex generator: six line vertices per particle position and field vector
// depends on hw/rtl/agvg_pkg.sv
//
// Each input transaction carries a position p and a field vector v; the block answers with six
// vertex transactions drawing an arrow as three segments: base, tip, barb a, tip, barb b, tip
// (tlast on the last tip). The tangent is v normalized, the sideways direction is the
// normalized dot(v,dv)*du - dot(v,du)*dv with du/dv the camera axes held in the configuration
// registers; barbs sit at 0.8 of the length plus or minus 0.1 sideways. A zero vector gives
// six copies of p; all coordinates saturate. The datapath is a 45 stage pipeline (direction
// scaling, dot and cross terms, two pipelined square roots at two result bits per stage, six
// pipelined dividers at two quotient bits per stage, offset multiply and saturating add). A
// new input can enter every cycle while the pipeline is not stalled; the single result
// channel emits one vertex per cycle while m_axis_tready is high and loads the next arrow
// only with the last tip. The pipeline stalls as a whole only while its last stage holds an
// arrow that the output serializer cannot yet take. Configuration may be written only while
// no arrow is in flight.

module arrow_glyph_vertex_generator
  import agvg_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // pos_x, pos_y, pos_z, vec_x, vec_y, vec_z from the lowest bit up
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // vert_x, vert_y, vert_z from the lowest bit up
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic                 m_axis_tlast,   // last_vertex
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_addr_i,
  input  logic [COORD_WIDTH-1:0] cfg_wdata_i
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned LW     = CW - 1;          // arrow length width
  localparam int unsigned OUT_W  = ((3*CW+7)/8)*8;
  localparam int unsigned LPW    = LW + 30;         // length times q30 constant
  localparam int unsigned MPW    = LW + 31;         // length times unit component
  localparam int unsigned OW     = CW + 2;          // signed offset
  localparam int unsigned SW     = CW + 3;          // position plus offset
  localparam int unsigned NSQ    = 16;              // square root stages
  localparam int unsigned NDV    = 16;              // divider stages
  localparam int unsigned DV_STP = 31;              // quotient bits
  localparam int unsigned NPIPE  = 10 + NSQ + NDV + 3;

  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] MAXV = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {4'b1111, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0][29:0]   tm;
    logic [2:0][29:0]   om;
    logic [2:0]         tneg;
    logic [2:0]         oneg;
  } side_t;

  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0]         tneg;
    logic [2:0]         oneg;
    logic [1:0][30:0]   r;
  } dside_t;

  typedef struct packed {
    logic [2:0][CW-1:0] base;
    logic [2:0][CW-1:0] tip;
    logic [2:0][CW-1:0] barb_a;
    logic [2:0][CW-1:0] barb_b;
  } arrow_t;

  // ---------------------------------------------------------------- configuration
  logic signed [CW-1:0] axu_q [3];
  logic signed [CW-1:0] axv_q [3];
  logic [LW-1:0]        len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axu_q[0] <= ONE;
      axu_q[1] <= ONE;
      axu_q[2] <= '0;
      axv_q[0] <= -ONE;
      axv_q[1] <= ONE;
      axv_q[2] <= '0;
      len_q    <= LW'(ONE);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_AXIS_U_X:     axu_q[0] <= cfg_wdata_i;
        REG_AXIS_U_Y:     axu_q[1] <= cfg_wdata_i;
        REG_AXIS_U_Z:     axu_q[2] <= cfg_wdata_i;
        REG_AXIS_V_X:     axv_q[0] <= cfg_wdata_i;
        REG_AXIS_V_Y:     axv_q[1] <= cfg_wdata_i;
        REG_AXIS_V_Z:     axv_q[2] <= cfg_wdata_i;
        REG_ARROW_LENGTH: len_q    <= cfg_wdata_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // derived configuration, refreshed every cycle; first read by the s3 axis products
  logic [63:0]          cu_m [3];
  logic [63:0]          cv_m [3];
  logic [63:0]          cu_mx, cv_mx;
  logic signed [24:0]   dus_d [3], dus_q [3];
  logic signed [24:0]   dvs_d [3], dvs_q [3];
  logic [LPW-1:0]       l08_p, l01_p;
  logic [LW-1:0]        l08_q, l01_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cu_m[i] = mag64(64'(axu_q[i]));
      cv_m[i] = mag64(64'(axv_q[i]));
    end
    cu_mx = max3(cu_m[0], cu_m[1], cu_m[2]);
    cv_mx = max3(cv_m[0], cv_m[1], cv_m[2]);
    for (int i = 0; i < 3; i++) begin
      dus_d[i] = 25'(to_s31(rescale_mag(cu_m[i], cu_mx, RS_K_AXIS), axu_q[i][CW-1]));
      dvs_d[i] = 25'(to_s31(rescale_mag(cv_m[i], cv_mx, RS_K_AXIS), axv_q[i][CW-1]));
    end
    // round half up
    l08_p = LPW'(len_q) * LPW'(K_08) + (LPW'(1) << 29);
    l01_p = LPW'(len_q) * LPW'(K_01) + (LPW'(1) << 29);
  end

  always_ff @(posedge clk_i) begin
    dus_q <= dus_d;
    dvs_q <= dvs_d;
    l08_q <= l08_p[LPW-1:30];
    l01_q <= l01_p[LPW-1:30];
  end

  // ---------------------------------------------------------------- flow control
  logic             adv;
  logic [NPIPE-1:0] vld_q;
  logic             ser_vld_q;
  logic             ser_load;
  vtx_e             cnt_q;

  assign ser_load      = !ser_vld_q || (m_axis_tready && (cnt_q == VTX_TIP2));
  assign adv           = !vld_q[NPIPE-1] || ser_load;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NPIPE-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------- s1: input capture
  logic [2:0][CW-1:0]   s1_p_q;
  logic signed [CW-1:0] s1_v_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_p_q[i] <= s_axis_tdata[i*CW +: CW];
        s1_v_q[i] <= s_axis_tdata[(3+i)*CW +: CW];
      end
    end
  end

  // ---------------------------------------------------------------- s2: scale v
  logic [63:0]        vm [3];
  logic [63:0]        vmx;
  logic signed [30:0] s2_v_d [3], s2_v_q [3];
  logic [2:0][CW-1:0] s2_p_q;

  always_comb begin
    for (int i = 0; i < 3; i++) vm[i] = mag64(64'(s1_v_q[i]));
    vmx = max3(vm[0], vm[1], vm[2]);
    for (int i = 0; i < 3; i++) begin
      s2_v_d[i] = to_s31(rescale_mag(vm[i], vmx, RS_K_DIR), s1_v_q[i][CW-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_v_q <= s2_v_d;
      s2_p_q <= s1_p_q;
    end
  end

  // ---------------------------------------------------------------- s3: v times axes
  logic signed [55:0] s3_pv_q [3], s3_pu_q [3];
  logic signed [30:0] s3_v_q [3];
  logic [2:0][CW-1:0] s3_p_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s3_pv_q[i] <= 56'(s2_v_q[i]) * 56'(dvs_q[i]);
        s3_pu_q[i] <= 56'(s2_v_q[i]) * 56'(dus_q[i]);
      end
      s3_v_q <= s2_v_q;
      s3_p_q <= s2_p_q;
    end
  end

  // ---------------------------------------------------------------- s4: dot products
  logic signed [56:0] s4_d0_q, s4_d1_q;
  logic signed [30:0] s4_v_q [3];
  logic [2:0][CW-1:0] s4_p_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_d0_q <= 57'(s3_pv_q[0]) + 57'(s3_pv_q[1]) + 57'(s3_pv_q[2]);
      s4_d1_q <= 57'(s3_pu_q[0]) + 57'(s3_pu_q[1]) + 57'(s3_pu_q[2]);
      s4_v_q  <= s3_v_q;
      s4_p_q  <= s3_p_q;
    end
  end

  // ---------------------------------------------------------------- s5: scale dot pair
  logic [63:0]        dm0, dm1, dmx;
  logic signed [24:0] s5_d0_q, s5_d1_q;
  logic signed [30:0] s5_v_q [3];
  logic [2:0][CW-1:0] s5_p_q;

  always_comb begin
    dm0 = mag64(64'(s4_d0_q));
    dm1 = mag64(64'(s4_d1_q));
    dmx = (dm0 > dm1) ? dm0 : dm1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_d0_q <= 25'(to_s31(rescale_mag(dm0, dmx, RS_K_AXIS), s4_d0_q[56]));
      s5_d1_q <= 25'(to_s31(rescale_mag(dm1, dmx, RS_K_AXIS), s4_d1_q[56]));
      s5_v_q  <= s4_v_q;
      s5_p_q  <= s4_p_q;
    end
  end

  // ---------------------------------------------------------------- s6: side terms
  logic signed [49:0] s6_q0_q [3], s6_q1_q [3];
  logic signed [30:0] s6_v_q [3];
  logic [2:0][CW-1:0] s6_p_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s6_q0_q[i] <= 50'(s5_d0_q) * 50'(dus_q[i]);
        s6_q1_q[i] <= 50'(s5_d1_q) * 50'(dvs_q[i]);
      end
      s6_v_q <= s5_v_q;
      s6_p_q <= s5_p_q;
    end
  end

  // ---------------------------------------------------------------- s7: side vector
  logic signed [50:0] s7_w_q [3];
  logic signed [30:0] s7_v_q [3];
  logic [2:0][CW-1:0] s7_p_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) s7_w_q[i] <= 51'(s6_q0_q[i]) - 51'(s6_q1_q[i]);
      s7_v_q <= s6_v_q;
      s7_p_q <= s6_p_q;
    end
  end

  // ---------------------------------------------------------------- s8: scale side vector
  logic [63:0]        wm [3];
  logic [63:0]        wmx;
  logic signed [30:0] s8_w_q [3];
  logic signed [30:0] s8_v_q [3];
  logic [2:0][CW-1:0] s8_p_q;

  always_comb begin
    for (int i = 0; i < 3; i++) wm[i] = mag64(64'(s7_w_q[i]));
    wmx = max3(wm[0], wm[1], wm[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s8_w_q[i] <= to_s31(rescale_mag(wm[i], wmx, RS_K_DIR), s7_w_q[i][50]);
      end
      s8_v_q <= s7_v_q;
      s8_p_q <= s7_p_q;
    end
  end

  // ---------------------------------------------------------------- s9: squares
  side_t       s9_side_d, s9_side_q;
  logic [59:0] s9_tsq_q [3], s9_osq_q [3];

  always_comb begin
    s9_side_d.p = s8_p_q;
    for (int i = 0; i < 3; i++) begin
      s9_side_d.tneg[i] = s8_v_q[i][30];
      s9_side_d.oneg[i] = s8_w_q[i][30];
      s9_side_d.tm[i]   = s8_v_q[i][30] ? 30'(-s8_v_q[i]) : s8_v_q[i][29:0];
      s9_side_d.om[i]   = s8_w_q[i][30] ? 30'(-s8_w_q[i]) : s8_w_q[i][29:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_side_q <= s9_side_d;
      for (int i = 0; i < 3; i++) begin
        s9_tsq_q[i] <= 60'(s9_side_d.tm[i]) * 60'(s9_side_d.tm[i]);
        s9_osq_q[i] <= 60'(s9_side_d.om[i]) * 60'(s9_side_d.om[i]);
      end
    end
  end

  // ---------------------------------------------------------------- s10: sums of squares
  side_t       s10_side_q;
  logic [61:0] s10_ss_q [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s10_side_q  <= s9_side_q;
      s10_ss_q[0] <= 62'(s9_tsq_q[0]) + 62'(s9_tsq_q[1]) + 62'(s9_tsq_q[2]);
      s10_ss_q[1] <= 62'(s9_osq_q[0]) + 62'(s9_osq_q[1]) + 62'(s9_osq_q[2]);
    end
  end

  // ---------------------------------------------------------------- square roots
  // two result bits per stage, lane 0 tangent, lane 1 side
  logic [61:0] sq_a_q    [NSQ][2];
  logic [62:0] sq_r_q    [NSQ][2];
  side_t       sq_side_q [NSQ];

  for (genvar s = 0; s < NSQ; s++) begin : g_sq
    logic [61:0] a_in [2];
    logic [62:0] r_in [2];
    side_t       side_in;
    logic [61:0] a_out [2];
    logic [62:0] r_out [2];

    if (s == 0) begin : g_first
      assign a_in    = s10_ss_q;
      assign r_in[0] = '0;
      assign r_in[1] = '0;
      assign side_in = s10_side_q;
    end else begin : g_next
      assign a_in    = sq_a_q[s-1];
      assign r_in    = sq_r_q[s-1];
      assign side_in = sq_side_q[s-1];
    end

    always_comb begin
      logic [63:0] a, r, b, t;
      for (int u = 0; u < 2; u++) begin
        a = 64'(a_in[u]);
        r = 64'(r_in[u]);
        for (int it = 0; it < 2; it++) begin
          b = 64'(1) << (62 - 2 * (2 * s + it));
          t = r + b;
          if (a >= t) begin
            a = a - t;
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
        end
        a_out[u] = a[61:0];
        r_out[u] = r[62:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_a_q[s]    <= a_out;
        sq_r_q[s]    <= r_out;
        sq_side_q[s] <= side_in;
      end
    end
  end

  // ---------------------------------------------------------------- dividers
  // unit component = c * 2^30 / r, two quotient bits per stage, lanes 0..2 tangent, 3..5 side
  logic [31:0] dv_rem_q  [NDV][6];
  logic [30:0] dv_quo_q  [NDV][6];
  dside_t      dv_side_q [NDV];

  for (genvar s = 0; s < NDV; s++) begin : g_dv
    logic [31:0] rem_in [6];
    logic [30:0] quo_in [6];
    logic [5:0]  c0;
    dside_t      side_in;
    logic [31:0] rem_out [6];
    logic [30:0] quo_out [6];

    if (s == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l]   = 32'(sq_side_q[NSQ-1].tm[l] >> 1);
        assign rem_in[l+3] = 32'(sq_side_q[NSQ-1].om[l] >> 1);
        assign c0[l]       = sq_side_q[NSQ-1].tm[l][0];
        assign c0[l+3]     = sq_side_q[NSQ-1].om[l][0];
        assign quo_in[l]   = '0;
        assign quo_in[l+3] = '0;
      end
      assign side_in.p    = sq_side_q[NSQ-1].p;
      assign side_in.tneg = sq_side_q[NSQ-1].tneg;
      assign side_in.oneg = sq_side_q[NSQ-1].oneg;
      assign side_in.r[0] = sq_r_q[NSQ-1][0][30:0];
      assign side_in.r[1] = sq_r_q[NSQ-1][1][30:0];
    end else begin : g_next
      assign rem_in  = dv_rem_q[s-1];
      assign quo_in  = dv_quo_q[s-1];
      assign c0      = '0;
      assign side_in = dv_side_q[s-1];
    end

    always_comb begin
      logic [31:0] rem, dvsr;
      logic [30:0] quo;
      for (int l = 0; l < 6; l++) begin
        rem  = rem_in[l];
        quo  = quo_in[l];
        dvsr = (l < 3) ? 32'(side_in.r[0]) : 32'(side_in.r[1]);
        for (int it = 0; it < 2; it++) begin
          if (2 * s + it < DV_STP) begin
            // only the first step brings in a nonzero numerator bit
            rem = {rem[30:0], (2 * s + it == 0) ? c0[l] : 1'b0};
            if (rem >= dvsr) begin
              rem = rem - dvsr;
              quo = {quo[29:0], 1'b1};
            end else begin
              quo = {quo[29:0], 1'b0};
            end
          end
        end
        rem_out[l] = rem;
        quo_out[l] = quo;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[s]  <= rem_out;
        dv_quo_q[s]  <= quo_out;
        dv_side_q[s] <= side_in;
      end
    end
  end

  // ---------------------------------------------------------------- sm: length times unit
  logic [30:0]        tq [3], oq [3];
  logic [MPW-1:0]     sm_len_q [3], sm_t08_q [3], sm_o01_q [3];
  logic [2:0][CW-1:0] sm_p_q;
  logic [2:0]         sm_tneg_q, sm_oneg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // a zero root means a zero vector, unit is zero
      tq[i] = (dv_side_q[NDV-1].r[0] == '0) ? '0 : dv_quo_q[NDV-1][i];
      oq[i] = (dv_side_q[NDV-1].r[1] == '0) ? '0 : dv_quo_q[NDV-1][i+3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sm_len_q[i] <= MPW'(len_q) * MPW'(tq[i]);
        sm_t08_q[i] <= MPW'(l08_q) * MPW'(tq[i]);
        sm_o01_q[i] <= MPW'(l01_q) * MPW'(oq[i]);
      end
      sm_p_q    <= dv_side_q[NDV-1].p;
      sm_tneg_q <= dv_side_q[NDV-1].tneg;
      sm_oneg_q <= dv_side_q[NDV-1].oneg;
    end
  end

  // ---------------------------------------------------------------- sr: round and sign
  function automatic logic signed [OW-1:0] signed_off(input logic [MPW-1:0] prod,
                                                      input logic neg);
    logic [MPW-1:0] rnd;
    logic [OW-1:0]  x;
    rnd = prod + (MPW'(1) << 29);
    x   = OW'(rnd[MPW-1:30]);
    return neg ? $signed(~x + OW'(1)) : $signed(x);
  endfunction

  logic signed [OW-1:0] ot [3], o8 [3], o1 [3];
  logic signed [OW-1:0] sr_tip_q [3], sr_ba_q [3], sr_bb_q [3];
  logic [2:0][CW-1:0]   sr_p_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ot[i] = signed_off(sm_len_q[i], sm_tneg_q[i]);
      o8[i] = signed_off(sm_t08_q[i], sm_tneg_q[i]);
      o1[i] = signed_off(sm_o01_q[i], sm_oneg_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sr_tip_q[i] <= ot[i];
        sr_ba_q[i]  <= o8[i] + o1[i];
        sr_bb_q[i]  <= o8[i] - o1[i];
      end
      sr_p_q <= sm_p_q;
    end
  end

  // ---------------------------------------------------------------- ss: saturating add
  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] p,
                                            input logic signed [OW-1:0] off);
    logic signed [SW-1:0] s;
    s = SW'($signed(p)) + SW'(off);
    if (s > MAXV) begin
      return MAXV[CW-1:0];
    end else if (s < MINV) begin
      return MINV[CW-1:0];
    end
    return s[CW-1:0];
  endfunction

  arrow_t ss_d, ss_q;

  always_comb begin
    ss_d.base = sr_p_q;
    for (int i = 0; i < 3; i++) begin
      ss_d.tip[i]    = sat_add(sr_p_q[i], sr_tip_q[i]);
      ss_d.barb_a[i] = sat_add(sr_p_q[i], sr_ba_q[i]);
      ss_d.barb_b[i] = sat_add(sr_p_q[i], sr_bb_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) ss_q <= ss_d;
  end

  // ---------------------------------------------------------------- output serializer
  arrow_t             ser_q;
  vtx_e               cnt_d;
  logic [2:0][CW-1:0] vsel;

  always_comb begin
    unique case (cnt_q)
      VTX_BASE:   cnt_d = VTX_TIP0;
      VTX_TIP0:   cnt_d = VTX_BARB_A;
      VTX_BARB_A: cnt_d = VTX_TIP1;
      VTX_TIP1:   cnt_d = VTX_BARB_B;
      VTX_BARB_B: cnt_d = VTX_TIP2;
      default:    cnt_d = VTX_BASE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      cnt_q     <= VTX_BASE;
    end else if (ser_load) begin
      ser_vld_q <= vld_q[NPIPE-1];
      cnt_q     <= VTX_BASE;
    end else if (m_axis_tready) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) ser_q <= ss_q;
  end

  always_comb begin
    case (cnt_q)
      VTX_BASE:   vsel = ser_q.base;
      VTX_BARB_A: vsel = ser_q.barb_a;
      VTX_BARB_B: vsel = ser_q.barb_b;
      default:    vsel = ser_q.tip;
    endcase
  end

  assign m_axis_tvalid = ser_vld_q;
  assign m_axis_tdata  = OUT_W'(vsel);
  assign m_axis_tlast  = (cnt_q == VTX_TIP2);

endmodule
